[design/triggered_capture_linear_upsampler_defines.svh]
// assertion macros for the triggered capture upsampler
// used by the top level; needs nothing else
`ifndef TRIGGERED_CAPTURE_LINEAR_UPSAMPLER_DEFINES_SVH
`define TRIGGERED_CAPTURE_LINEAR_UPSAMPLER_DEFINES_SVH

// same-cycle implication
`define TCU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/tcu_pkg.sv]
// types and constants of the triggered capture upsampler
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package tcu_pkg;

  localparam int MAX_FRAME = 4096;

  typedef logic [11:0]        adc_t;
  typedef logic signed [15:0] pcm_t;
  typedef logic [1:0]         reg_idx_t;
  typedef logic [13:0]        cfg_data_t;

  localparam reg_idx_t REG_QUIET_LOW  = 2'd0;
  localparam reg_idx_t REG_QUIET_HIGH = 2'd1;
  localparam reg_idx_t REG_SRC_SPAN   = 2'd2;
  localparam reg_idx_t REG_DST_SPAN   = 2'd3;

  localparam logic [11:0] QUIET_LOW_RST  = 12'd1548;
  localparam logic [11:0] QUIET_HIGH_RST = 12'd2548;
  localparam logic [11:0] SRC_SPAN_RST   = 12'd3806;
  localparam logic [13:0] DST_SPAN_RST   = 14'd6767;

  // largest usable source span
  localparam logic [11:0] MAX_SRC_SPAN =
    (MAX_FRAME - 1 > 4095) ? 12'd4095 : 12'(MAX_FRAME - 1);

  // interior outputs per word
  localparam logic [2:0] MAX_INTERIOR = 3'd4;

  // divider step counts
  localparam logic [3:0] FOLD_STEPS = 4'd14;
  localparam logic [3:0] FRAC_STEPS = 4'd15;

endpackage

`default_nettype wire

[design/tcu_adc_if.sv]
// input channel: raw converter word with valid/ready
// depends on tcu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tcu_adc_if;
  import tcu_pkg::*;

  logic valid;
  logic ready;
  adc_t adc_sample;

  modport source(output valid, output adc_sample, input ready);
  modport sink(input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

[design/tcu_pcm_if.sv]
// output channel: interpolated pcm word and frame end flag with valid/ready
// depends on tcu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tcu_pcm_if;
  import tcu_pkg::*;

  logic valid;
  logic ready;
  pcm_t pcm_out;
  logic frame_end;

  modport source(output valid, output pcm_out, output frame_end, input ready);
  modport sink(input valid, input pcm_out, input frame_end, output ready);
endinterface

`default_nettype wire

[design/triggered_capture_linear_upsampler.sv]
// channel     dir   payload                    handshake
// adc         in    adc_sample[11:0]           valid/ready
// pcm         out   pcm_out[15:0], frame_end   valid/ready
// cfg         in    cfg_index, cfg_data        cfg_we, no wait
//
// a word outside a frame or opening one is handled in idle alone, any other goes
// through accept and check; each interior output adds check, a 15-step serial
// fraction divide, multiply and emit, a remainder folded after a span change adds
// a fold through the restoring divider and the frame end word a final state; the
// divider makes one quotient bit per cycle.
// rst is synchronous; a stalled pcm word holds the sequencer at its output.
// files: tcu_pkg, tcu_adc_if, tcu_pcm_if, assertion macros header
`timescale 1ns / 1ps
`default_nettype none

`include "triggered_capture_linear_upsampler_defines.svh"

module triggered_capture_linear_upsampler (
  input  wire logic                clk,
  input  wire logic                rst,
  tcu_adc_if.sink                  adc,
  tcu_pcm_if.source                pcm,
  input  wire logic                cfg_we,
  input  wire tcu_pkg::reg_idx_t   cfg_index,
  input  wire tcu_pkg::cfg_data_t  cfg_data
);
  import tcu_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FOLD  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_FRAC  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_FINAL = 3'd6;

  logic [11:0] quiet_low, quiet_high, src_span;
  logic [13:0] dst_span;

  logic [2:0]  state;
  logic        armed;
  logic [12:0] samples_taken;
  pcm_t        previous_pcm;
  pcm_t        cur_pcm;
  logic [11:0] k_idx;
  logic [11:0] next_floor_index;
  logic [13:0] phase_remainder;
  logic [2:0]  n_out;

  logic [13:0] pr;
  logic [14:0] num;
  logic [14:0] quo;
  logic [3:0]  cnt;
  logic signed [31:0] prod;

  logic        out_valid;
  pcm_t        out_pcm;
  logic        out_end;

  // clamped spans
  logic [11:0] s_one, s_eff;
  logic [13:0] s_ext, s_four, d_eff;

  always_comb begin
    s_one  = (src_span == 12'd0) ? 12'd1 : src_span;
    s_eff  = (s_one > MAX_SRC_SPAN) ? MAX_SRC_SPAN : s_one;
    s_ext  = {2'b00, s_eff};
    s_four = {s_eff, 2'b00};
    if (dst_span < s_ext) begin
      d_eff = s_ext;
    end else if (dst_span > s_four) begin
      d_eff = s_four;
    end else begin
      d_eff = dst_span;
    end
  end

  // input word decode
  logic        accept, loud, stop;
  pcm_t        pcm_in;
  assign accept = adc.valid && adc.ready;
  assign loud   = (adc.adc_sample < quiet_low) || (adc.adc_sample > quiet_high);
  assign pcm_in = {~adc.adc_sample[11], adc.adc_sample[10:0], 4'b0000};
  assign stop   = samples_taken >= ({1'b0, s_eff} + 13'd1);

  // shared restoring divider step
  logic [14:0] trial;
  logic        trial_ge;
  logic [13:0] pr_next;
  logic [14:0] quo_next;
  logic [14:0] trial_sub;
  assign trial     = {pr, num[14]};
  assign trial_ge  = trial >= {1'b0, d_eff};
  assign trial_sub = trial - {1'b0, d_eff};
  assign pr_next   = trial_ge ? trial_sub[13:0] : trial[13:0];
  assign quo_next  = {quo[13:0], trial_ge};

  // phase advance by one source span
  logic [14:0] adv_sum, adv_sub;
  logic        adv_ge;
  assign adv_sum = {1'b0, phase_remainder} + {3'b000, s_eff};
  assign adv_ge  = adv_sum >= {1'b0, d_eff};
  assign adv_sub = adv_sum - {1'b0, d_eff};

  logic signed [16:0] diff;
  logic signed [33:0] prod_full;
  assign diff      = {cur_pcm[15], cur_pcm} - {previous_pcm[15], previous_pcm};
  assign prod_full = diff * $signed({2'b00, quo});

  logic out_free;
  assign out_free = !out_valid || pcm.ready;

  assign adc.ready     = (state == ST_IDLE);
  assign pcm.valid     = out_valid;
  assign pcm.pcm_out   = out_pcm;
  assign pcm.frame_end = out_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_low  <= QUIET_LOW_RST;
      quiet_high <= QUIET_HIGH_RST;
      src_span   <= SRC_SPAN_RST;
      dst_span   <= DST_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUIET_LOW:  quiet_low  <= cfg_data[11:0];
        REG_QUIET_HIGH: quiet_high <= cfg_data[11:0];
        REG_SRC_SPAN:   src_span   <= cfg_data[11:0];
        REG_DST_SPAN:   dst_span   <= cfg_data;
        default:        quiet_low  <= quiet_low;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      armed            <= 1'b0;
      samples_taken    <= '0;
      previous_pcm     <= '0;
      next_floor_index <= '0;
      phase_remainder  <= '0;
      out_valid        <= 1'b0;
      n_out            <= '0;
      cnt              <= '0;
    end else begin
      if (out_valid && pcm.ready && !(state inside {ST_EMIT, ST_FINAL})) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (armed || loud)) begin
            armed <= !stop;
            if (stop) begin
              samples_taken <= '0;
            end else begin
              samples_taken <= samples_taken + 13'd1;
              k_idx         <= samples_taken[11:0];
              cur_pcm       <= pcm_in;
              n_out         <= '0;
              if (samples_taken == 13'd0) begin
                next_floor_index <= '0;
                phase_remainder  <= '0;
                previous_pcm     <= pcm_in;
              end else if (phase_remainder >= d_eff) begin
                pr    <= '0;
                num   <= {phase_remainder, 1'b0};
                quo   <= '0;
                cnt   <= FOLD_STEPS;
                state <= ST_FOLD;
              end else begin
                state <= ST_CHECK;
              end
            end
          end
        end
        ST_FOLD: begin
          pr  <= pr_next;
          num <= {num[13:0], 1'b0};
          quo <= quo_next;
          cnt <= cnt - 4'd1;
          if (cnt == 4'd1) begin
            next_floor_index <= next_floor_index + quo_next[11:0];
            phase_remainder  <= pr_next;
            state            <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if ((n_out < MAX_INTERIOR) && (next_floor_index == (k_idx - 12'd1))) begin
            pr    <= phase_remainder;
            num   <= '0;
            quo   <= '0;
            cnt   <= FRAC_STEPS;
            state <= ST_FRAC;
          end else if (k_idx == s_eff) begin
            state <= ST_FINAL;
          end else begin
            previous_pcm <= cur_pcm;
            state        <= ST_IDLE;
          end
        end
        ST_FRAC: begin
          pr  <= pr_next;
          num <= {num[13:0], 1'b0};
          quo <= quo_next;
          cnt <= cnt - 4'd1;
          if (cnt == 4'd1) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= prod_full[31:0];
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_pcm   <= previous_pcm + prod[30:15];
            out_end   <= 1'b0;
            n_out     <= n_out + 3'd1;
            if (adv_ge) begin
              phase_remainder  <= adv_sub[13:0];
              next_floor_index <= next_floor_index + 12'd1;
            end else begin
              phase_remainder <= adv_sum[13:0];
            end
            state <= ST_CHECK;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_pcm      <= cur_pcm;
            out_end      <= 1'b1;
            previous_pcm <= cur_pcm;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TCU_ASSERT_NOW(a_disarmed_count_clear, clk, rst, !armed, samples_taken == 13'd0,
                  "count set while disarmed")
  `TCU_ASSERT_NOW(a_phase_reduced, clk, rst, state == ST_CHECK, phase_remainder < d_eff,
                  "phase remainder not reduced")
  `TCU_ASSERT_NOW(a_div_partial, clk, rst, (state == ST_FOLD) || (state == ST_FRAC),
                  pr < d_eff, "divider partial remainder out of range")
  `TCU_ASSERT_NOW(a_interior_cap, clk, rst, state == ST_EMIT, n_out < MAX_INTERIOR,
                  "too many interior words")
  `TCU_ASSERT_NEXT(a_final_to_idle, clk, rst, (state == ST_FINAL) && out_free,
                   (state == ST_IDLE) && out_end, "frame end word not issued")

endmodule

`default_nettype wire

[dv/tcu_upsample_checker.sv]
`timescale 1ns / 1ps
// checker for the triggered capture upsampler: follows register writes and
// accepted adc words, predicts each pcm word and compares them in order
// depends on tcu_pkg, tcu_adc_if and tcu_pcm_if
module tcu_upsample_checker
  import tcu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tcu_adc_if        adc_mon,
  tcu_pcm_if        pcm_mon,
  input  logic      cfg_we,
  input  reg_idx_t  cfg_index,
  input  cfg_data_t cfg_data,
  output int        mismatches,
  output int        pending,
  output int        results_seen,
  output int        frames_seen
);

  typedef struct packed {
    pcm_t pcm;
    logic frame_end;
  } pcm_word_t;

  pcm_word_t pcm_expected[$];

  logic [11:0] band_lo, band_hi, span_in;
  logic [13:0] span_out;
  logic        capturing;
  int unsigned taken, floor_idx, phase;
  int          last_pcm;

  function automatic void push_pcm(input int val, input logic fin);
    pcm_word_t w;
    w.pcm = pcm_t'(val);
    w.frame_end = fin;
    pcm_expected.push_back(w);
  endfunction

  function automatic void predict_word(input adc_t a);
    int unsigned s, d, k, frac;
    int          cur, n;
    longint      prod;
    if (a < band_lo || a > band_hi) capturing = 1'b1;
    if (!capturing) return;
    s = span_in;
    if (s < 1) s = 1;
    if (s > MAX_SRC_SPAN) s = MAX_SRC_SPAN;
    d = span_out;
    if (d < s) d = s;
    if (d > 4 * s) d = 4 * s;
    cur = (int'(a) - 2048) * 16;
    // past the end of the frame: swallow and disarm
    if (taken >= s + 1) begin
      capturing = 1'b0;
      taken = 0;
      return;
    end
    k = taken;
    taken = (taken + 1) & 32'h1FFF;
    if (k == 0) begin
      floor_idx = 0;
      phase = 0;
      last_pcm = cur;
      return;
    end
    // remainder left over from a larger output span
    if (phase >= d) begin
      floor_idx = (floor_idx + phase / d) & 32'hFFF;
      phase = phase % d;
    end
    n = 0;
    while (n < 4 && floor_idx == k - 1) begin
      frac = (phase * 32768) / d;
      prod = longint'(cur - last_pcm) * longint'(frac);
      push_pcm(last_pcm + int'(prod >>> 15), 1'b0);
      n++;
      phase = phase + s;
      floor_idx = (floor_idx + phase / d) & 32'hFFF;
      phase = phase % d;
    end
    if (k == s) push_pcm(cur, 1'b1);
    last_pcm = cur;
  endfunction

  always @(posedge clk) begin
    pcm_word_t want;
    if (rst) begin
      band_lo = QUIET_LOW_RST;
      band_hi = QUIET_HIGH_RST;
      span_in = SRC_SPAN_RST;
      span_out = DST_SPAN_RST;
      capturing = 1'b0;
      taken = 0;
      floor_idx = 0;
      phase = 0;
      last_pcm = 0;
      pcm_expected.delete();
      mismatches = 0;
      results_seen = 0;
      frames_seen = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_QUIET_LOW:  band_lo = cfg_data[11:0];
          REG_QUIET_HIGH: band_hi = cfg_data[11:0];
          REG_SRC_SPAN:   span_in = cfg_data[11:0];
          REG_DST_SPAN:   span_out = cfg_data;
          default: ;
        endcase
      end
      if (adc_mon.valid && adc_mon.ready) predict_word(adc_mon.adc_sample);
      if (pcm_mon.valid && pcm_mon.ready) begin
        results_seen++;
        if (pcm_mon.frame_end) frames_seen++;
        if (pcm_expected.size() == 0) begin
          mismatches++;
          $display("%0t: pcm word with none expected: pcm_out %0d frame_end %0b",
                   $time, pcm_mon.pcm_out, pcm_mon.frame_end);
        end else begin
          want = pcm_expected.pop_front();
          if (want.pcm !== pcm_mon.pcm_out) begin
            mismatches++;
            $display("%0t: pcm_out expected %0d got %0d", $time, want.pcm, pcm_mon.pcm_out);
          end
          if (want.frame_end !== pcm_mon.frame_end) begin
            mismatches++;
            $display("%0t: frame_end expected %0b got %0b",
                     $time, want.frame_end, pcm_mon.frame_end);
          end
        end
      end
      pending <= pcm_expected.size();
    end
  end

endmodule

[dv/triggered_capture_linear_upsampler_tb.sv]
`timescale 1ns / 1ps
// top of the upsampler testbench: clock, reset, register writes, adc stimulus
// and pcm back-pressure; checking lives in tcu_upsample_checker
// depends on tcu_pkg, tcu_adc_if, tcu_pcm_if and the block itself
module triggered_capture_linear_upsampler_tb;
  import tcu_pkg::*;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  reg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  int mismatches, pending, results_seen, frames_seen;
  int words_sent = 0;
  int settings_done = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  logic [11:0] ql, qh, ss;

  tcu_adc_if adc_ch ();
  tcu_pcm_if pcm_ch ();

  triggered_capture_linear_upsampler dut (
    .clk(clk),
    .rst(rst),
    .adc(adc_ch),
    .pcm(pcm_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  tcu_upsample_checker chk (
    .clk(clk),
    .rst(rst),
    .adc_mon(adc_ch),
    .pcm_mon(pcm_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .pending(pending),
    .results_seen(results_seen),
    .frames_seen(frames_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    pcm_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #20_000_000;
    $display("triggered_capture_linear_upsampler verification failed");
    $finish;
  end

  task automatic send_word(input adc_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      adc_ch.valid <= 1'b0;
      @(posedge clk);
    end
    adc_ch.valid <= 1'b1;
    adc_ch.adc_sample <= v;
    @(posedge clk);
    while (!adc_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // hold the sender until every predicted word is out, then let the block settle
  task automatic wait_idle();
    adc_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_one(input reg_idx_t idx, input cfg_data_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [11:0] lo, input logic [11:0] hi,
                          input logic [11:0] sspan, input logic [13:0] dspan);
    ql = lo;
    qh = hi;
    ss = sspan;
    write_one(REG_QUIET_LOW, cfg_data_t'(lo));
    write_one(REG_QUIET_HIGH, cfg_data_t'(hi));
    write_one(REG_SRC_SPAN, cfg_data_t'(sspan));
    write_one(REG_DST_SPAN, dspan);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  function automatic int frame_span();
    return (ss == 0) ? 1 : int'(ss);
  endfunction

  function automatic logic [13:0] pick_dst(input int s);
    case ($urandom_range(0, 5))
      0: return 14'(s);
      1: return 14'(4 * s);
      2: return '0;
      3: return 14'h3FFF;
      default: return 14'($urandom_range(s, 4 * s));
    endcase
  endfunction

  function automatic adc_t loud_sample();
    if (qh == 12'hFFF || (ql != 0 && $urandom_range(0, 1) == 0))
      return adc_t'($urandom_range(0, ql - 1));
    return adc_t'($urandom_range(qh + 1, 4095));
  endfunction

  function automatic adc_t quiet_sample();
    if (ql <= qh) return adc_t'($urandom_range(ql, qh));
    return adc_t'($urandom_range(0, 4095));
  endfunction

  function automatic adc_t frame_sample();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'hFFF;
      2, 3: return adc_t'($urandom_range(1900, 2200));
      default: return adc_t'($urandom_range(0, 4095));
    endcase
  endfunction

  // quiet lead-in, a trigger, the frame body and one trailing word;
  // now and then the body is cut short
  task automatic send_frame();
    int span;
    repeat ($urandom_range(0, 2)) send_word(quiet_sample());
    send_word(loud_sample());
    span = frame_span();
    if ($urandom_range(0, 5) == 0) span = $urandom_range(0, span);
    repeat (span) send_word(frame_sample());
    send_word(frame_sample());
  endtask

  task automatic run_phase(input int idx, input int n_words);
    int          start;
    logic        changed;
    logic [11:0] s_new;
    wait_idle();
    case (idx % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
    s_new = (idx == 5) ? 12'($urandom_range(24, 48)) : 12'($urandom_range(1, 10));
    set_regs(12'($urandom_range(1700, 2048)), 12'($urandom_range(2048, 2400)),
             s_new, pick_dst(s_new));
    start = words_sent;
    changed = 1'b0;
    while (words_sent - start < n_words) begin
      send_frame();
      // span change once half of the phase's words are sent
      if (!changed && words_sent - start >= n_words / 2) begin
        wait_idle();
        s_new = $urandom_range(0, 1) ? 12'($urandom_range(1, 10)) : ss;
        set_regs(ql, qh, s_new, pick_dst(s_new));
        changed = 1'b1;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_QUIET_LOW;
    cfg_data <= '0;
    adc_ch.valid <= 1'b0;
    adc_ch.adc_sample <= '0;
    ql = QUIET_LOW_RST;
    qh = QUIET_HIGH_RST;
    ss = SRC_SPAN_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset band: edges stay quiet, one below arms
    send_word(12'd2048);
    send_word(12'd1548);
    send_word(12'd2548);
    send_word(12'd1547);
    send_word(12'd0);
    send_word(12'hFFF);
    send_word(12'd2549);

    // span shrinks below the count: next word is swallowed
    wait_idle();
    set_regs(QUIET_LOW_RST, QUIET_HIGH_RST, 12'd1, 14'd4);
    send_word(12'd2048);
    // two-word frame, five words out of the second
    send_word(12'hFFF);
    send_word(12'd0);
    send_word(12'd2048);

    // band covers everything, spans clamp up to one
    wait_idle();
    set_regs(12'd0, 12'hFFF, 12'd0, 14'd0);
    send_word(12'd0);
    send_word(12'hFFF);

    // inverted band arms on anything, output span clamps down
    wait_idle();
    set_regs(12'hFFF, 12'd0, 12'd2, 14'h3FFF);
    send_word(12'd2048);
    send_word(12'hFFF);
    send_word(12'd0);
    send_word(12'd1234);

    // widest spans, then cut short
    wait_idle();
    set_regs(QUIET_LOW_RST, QUIET_HIGH_RST, 12'hFFF, 14'h3FFF);
    send_word(12'd0);
    send_word(12'hFFF);
    send_word(12'd0);
    send_word(12'hFFF);
    send_word(12'd2048);
    send_word(12'd1);
    wait_idle();
    set_regs(QUIET_LOW_RST, QUIET_HIGH_RST, 12'd1, 14'd2);
    send_word(12'd2048);

    for (int p = 0; p < 8; p++) run_phase(p, 55);
    wait_idle();

    $display("run covered %0d adc words over %0d register settings", words_sent,
             settings_done);
    $display("%0d pcm words checked, %0d frames closed, all four idling modes",
             results_seen, frames_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("triggered_capture_linear_upsampler verification clean");
    end else begin
      $display("triggered_capture_linear_upsampler verification failed");
    end
    $finish;
  end

endmodule
